// ===== rtl/fig_pkg.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// fig_pkg: field interpolation gather package
// Widths, codes and record types shared by the gather datapath and its testbench.
// -----------------------------------------------------------------------------
package fig_pkg;

  localparam int unsigned FIELD_DEPTH = 65536;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned ADDR_W      = $clog2(FIELD_DEPTH);

  localparam int unsigned IDX_W       = 16;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned LEN_W       = 32;
  localparam int unsigned WT_W        = 17;
  localparam int unsigned WEIGHT_FRAC = 16;
  localparam logic [WT_W-1:0] WEIGHT_ONE = WT_W'(2 ** WEIGHT_FRAC);
  localparam int unsigned AVG_SHIFT   = 2;

  localparam int unsigned SMP_W  = 48;
  localparam int unsigned ACC_W  = SMP_W + 2;
  localparam int unsigned DIFF_W = SMP_W + 1;

  localparam int unsigned DIV_BITS      = VAL_W + FRAC_BITS;
  localparam int unsigned DIV_STEP_BITS = 2;
  localparam int unsigned DIV_STAGES    = (DIV_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
  localparam int unsigned DQ_W          = DIV_STAGES * DIV_STEP_BITS;
  localparam int unsigned QX_W          = (DQ_W > SMP_W) ? DQ_W : SMP_W + 1;

  localparam logic [QX_W-1:0] SMP_NEG_LIM = QX_W'(1) << (SMP_W - 1);
  localparam logic [QX_W-1:0] SMP_POS_LIM = SMP_NEG_LIM - QX_W'(1);

  localparam int unsigned MUL_LO_W = 24;
  localparam int unsigned MUL_HI_W = DIFF_W - MUL_LO_W;
  localparam int unsigned P_LO_W   = MUL_LO_W + WT_W;
  localparam int unsigned P_HI_W   = MUL_HI_W + WT_W + 1;
  localparam int unsigned SUM_W    = ACC_W + 2;

  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W - 1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W - 1){1'b0}}};

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_EVAL  = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    FORM_ZERO = 2'd0,
    FORM_RAW  = 2'd1,
    FORM_LERP = 2'd2,
    FORM_AVG4 = 2'd3
  } form_e;

  // per-sample tag carried down the divider
  typedef struct packed {
    logic              first;
    logic              last;
    logic              zero;
    form_e             form;
    logic [WT_W-1:0]   weight;
    logic [LEN_W-1:0]  len;
  } tag_t;

  typedef struct packed {
    tag_t              tag;
    logic              neg;
    logic [LEN_W-1:0]  rem;
    logic [DQ_W-1:0]   dq;
  } div_t;

  typedef struct packed {
    logic                     first;
    logic                     last;
    form_e                    form;
    logic [WT_W-1:0]          weight;
    logic                     clip;
    logic signed [SMP_W-1:0]  value;
  } smp_t;

  // remaining samples b, c, d of an entry in flight
  typedef struct packed {
    form_e                   form;
    logic [WT_W-1:0]         weight;
    logic [2:0][IDX_W-1:0]   idx;
    logic [2:0][LEN_W-1:0]   len;
  } item_t;

  function automatic logic [ADDR_W-1:0] field_addr(input logic [IDX_W-1:0] idx);
    logic [IDX_W+ADDR_W-1:0] wide;
    wide = {{ADDR_W{1'b0}}, idx};
    return wide[ADDR_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/fig_ram.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// fig_ram: single-port synchronous RAM
// One access per cycle, write or read; read data is registered and holds
// until the next read.
// -----------------------------------------------------------------------------
module fig_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [0:DEPTH-1];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/field_interpolation_gather.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// field_interpolation_gather: field memory with sample gather and blend
// Write beats load the field memory; evaluate beats read up to four words,
// divide each by its edge length, pass, blend or average them and saturate.
//
//   channel | handshake              | fields
//   --------+------------------------+------------------------------------------
//   in      | in_valid_i / in_stall_o | req_type, write_value, form, index_a..d,
//           |                        | length_a..d, blend_weight
//   out     | out_valid_o / out_stall_i | node_value, saturated
//
// one RAM port: a lerp or avg4 beat holds in_stall_o while its later samples issue
// results are signed Q16.16, built from field word / edge length quotients
// registered path: RAM read, divider, sample clamp, accumulate, blend multiply, sum, output
// the divider is a 2-bit-per-stage restoring pipeline behind the RAM read
// reset clears control only; the field memory is undefined until written
// a held result stalls the pipeline only when another result is waiting behind it
// -----------------------------------------------------------------------------
module field_interpolation_gather import fig_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,

  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     req_type_i,
  input  logic signed [VAL_W-1:0]  write_value_i,
  input  logic [1:0]               form_i,
  input  logic [IDX_W-1:0]         index_a_i,
  input  logic [IDX_W-1:0]         index_b_i,
  input  logic [IDX_W-1:0]         index_c_i,
  input  logic [IDX_W-1:0]         index_d_i,
  input  logic [LEN_W-1:0]         length_a_i,
  input  logic [LEN_W-1:0]         length_b_i,
  input  logic [LEN_W-1:0]         length_c_i,
  input  logic [LEN_W-1:0]         length_d_i,
  input  logic [WT_W-1:0]          blend_weight_i,

  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [VAL_W-1:0]  node_value_o,
  output logic                     saturated_o
);

  logic              adv;

  // issue
  logic              busy_q, busy_d;
  logic [1:0]        cnt_q, cnt_d;
  item_t             item_q;
  logic              fire;
  logic              is_write;
  logic [1:0]        slot;
  logic [1:0]        last_slot;
  form_e             cur_form;
  logic [IDX_W-1:0]  cur_idx;
  logic [LEN_W-1:0]  cur_len;
  logic [WT_W-1:0]   cur_wt;
  logic [WT_W-1:0]   in_wt;
  logic              cur_zero;

  logic              ram_en;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [VAL_W-1:0]  ram_rdata;

  // read data stage
  logic              s1_vld_q;
  tag_t              s1_q;
  div_t              div_init;
  logic [VAL_W-1:0]  mag;

  // divider
  div_t              div_q [0:DIV_STAGES];
  logic [DIV_STAGES:0] div_vld_q;

  // sample
  div_t              div_last;
  logic [QX_W-1:0]   q_ext;
  logic [SMP_W-1:0]  q_lo;
  smp_t              smp_d, smp_q;
  logic              smp_vld_q;

  // accumulate
  logic signed [ACC_W-1:0]  s_ext;
  logic signed [ACC_W-1:0]  acc_sum;
  logic                     clip_all;
  logic signed [ACC_W-1:0]  acc_q;
  logic                     acc_clip_q;
  logic signed [ACC_W-1:0]  rec_base_d, rec_base_q;
  logic signed [DIFF_W-1:0] rec_diff_d, rec_diff_q;
  logic [WT_W-1:0]          rec_w_d, rec_w_q;
  logic                     rec_clip_q;
  logic                     rec_vld_q;

  // blend multiply
  logic [MUL_LO_W-1:0]       mul_dl;
  logic [MUL_HI_W-1:0]       mul_dh;
  logic [P_LO_W-1:0]         mul_plo_d, mul_plo_q;
  logic signed [P_HI_W-1:0]  mul_phi_d, mul_phi_q;
  logic signed [ACC_W-1:0]   mul_base_q;
  logic                      mul_clip_q;
  logic                      mul_vld_q;

  // sum
  logic signed [SUM_W-1:0]   t_base, t_hi, t_lo;
  logic signed [SUM_W-1:0]   sum_d, sum_q;
  logic                      sum_clip_q;
  logic                      sum_vld_q;

  // output
  logic [SUM_W-VAL_W:0]      sum_hi;
  logic                      ovf_pos, ovf_neg;
  logic [VAL_W-1:0]          node_d;
  logic                      out_valid_q;
  logic [VAL_W-1:0]          node_value_q;
  logic                      saturated_q;

  function automatic logic [1:0] last_of(input form_e f);
    logic [1:0] r;
    unique case (f)
      FORM_ZERO: r = 2'd0;
      FORM_RAW:  r = 2'd0;
      FORM_LERP: r = 2'd1;
      FORM_AVG4: r = 2'd3;
    endcase
    return r;
  endfunction

  function automatic div_t div_step(input div_t d);
    div_t         r;
    logic [LEN_W:0] sh;
    r = d;
    for (int i = 0; i < DIV_STEP_BITS; i++) begin
      sh   = {r.rem, r.dq[DQ_W-1]};
      r.dq = {r.dq[DQ_W-2:0], 1'b0};
      if (sh >= {1'b0, r.tag.len}) begin
        r.rem   = LEN_W'(sh - {1'b0, r.tag.len});
        r.dq[0] = 1'b1;
      end else begin
        r.rem = sh[LEN_W-1:0];
      end
    end
    return r;
  endfunction

  assign adv        = !(out_valid_q && out_stall_i && sum_vld_q);
  assign in_stall_o = busy_q || !adv;

  // ---------------------------------------------------------------------------
  // issue: while not stalled, one RAM access per cycle
  // ---------------------------------------------------------------------------
  always_comb begin
    in_wt = (blend_weight_i > WEIGHT_ONE) ? WEIGHT_ONE : blend_weight_i;
    if (busy_q) begin
      fire     = adv;
      is_write = 1'b0;
      slot     = cnt_q;
      cur_form = item_q.form;
      cur_wt   = item_q.weight;
      unique case (cnt_q)
        2'd1: begin
          cur_idx = item_q.idx[0];
          cur_len = item_q.len[0];
        end
        2'd2: begin
          cur_idx = item_q.idx[1];
          cur_len = item_q.len[1];
        end
        default: begin
          cur_idx = item_q.idx[2];
          cur_len = item_q.len[2];
        end
      endcase
    end else begin
      fire     = in_valid_i && adv;
      is_write = (req_e'(req_type_i) == REQ_WRITE);
      slot     = 2'd0;
      cur_form = form_e'(form_i);
      cur_wt   = in_wt;
      cur_idx  = index_a_i;
      cur_len  = length_a_i;
    end

    last_slot = last_of(cur_form);
    cur_zero  = (cur_form == FORM_ZERO) || (cur_len == '0);

    ram_en   = fire && (is_write || !cur_zero);
    ram_we   = is_write;
    ram_addr = field_addr(cur_idx);

    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (fire && !is_write) begin
      if (slot == last_slot) begin
        busy_d = 1'b0;
        cnt_d  = 2'd0;
      end else begin
        busy_d = 1'b1;
        cnt_d  = slot + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      cnt_q    <= 2'd0;
      s1_vld_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      if (adv) begin
        s1_vld_q <= fire && !is_write;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && !busy_q) begin
      item_q.form   <= cur_form;
      item_q.weight <= in_wt;
      item_q.idx    <= {index_d_i, index_c_i, index_b_i};
      item_q.len    <= {length_d_i, length_c_i, length_b_i};
    end
    if (adv) begin
      s1_q.first  <= (slot == 2'd0);
      s1_q.last   <= (slot == last_slot);
      s1_q.zero   <= cur_zero;
      s1_q.form   <= cur_form;
      s1_q.weight <= cur_wt;
      s1_q.len    <= cur_len;
    end
  end

  fig_ram #(
    .WIDTH (VAL_W),
    .DEPTH (FIELD_DEPTH)
  ) u_field_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (write_value_i),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // read data into divider
  // ---------------------------------------------------------------------------
  always_comb begin
    div_init.tag = s1_q;
    div_init.neg = !s1_q.zero && ram_rdata[VAL_W-1];
    mag          = s1_q.zero ? '0 : (div_init.neg ? -ram_rdata : ram_rdata);
    div_init.rem = '0;
    div_init.dq  = DQ_W'({mag, {FRAC_BITS{1'b0}}});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_vld_q <= '0;
    end else if (adv) begin
      div_vld_q <= {div_vld_q[DIV_STAGES-1:0], s1_vld_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      div_q[0] <= div_init;
      for (int k = 1; k <= DIV_STAGES; k++) begin
        div_q[k] <= div_step(div_q[k-1]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // signed sample with 48-bit clamp
  // ---------------------------------------------------------------------------
  always_comb begin
    div_last     = div_q[DIV_STAGES];
    q_ext        = QX_W'(div_last.dq);
    q_lo         = q_ext[SMP_W-1:0];
    smp_d.first  = div_last.tag.first;
    smp_d.last   = div_last.tag.last;
    smp_d.form   = div_last.tag.form;
    smp_d.weight = div_last.tag.weight;
    if (div_last.tag.zero) begin
      smp_d.clip  = 1'b0;
      smp_d.value = '0;
    end else if (!div_last.neg) begin
      if (q_ext > SMP_POS_LIM) begin
        smp_d.clip  = 1'b1;
        smp_d.value = signed'(SMP_POS_LIM[SMP_W-1:0]);
      end else begin
        smp_d.clip  = 1'b0;
        smp_d.value = signed'(q_lo);
      end
    end else begin
      if (q_ext > SMP_NEG_LIM) begin
        smp_d.clip  = 1'b1;
        smp_d.value = signed'(SMP_NEG_LIM[SMP_W-1:0]);
      end else begin
        smp_d.clip  = 1'b0;
        smp_d.value = signed'(-q_lo);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_vld_q <= 1'b0;
    end else if (adv) begin
      smp_vld_q <= div_vld_q[DIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      smp_q <= smp_d;
    end
  end

  // ---------------------------------------------------------------------------
  // accumulate samples of one entry
  // ---------------------------------------------------------------------------
  always_comb begin
    s_ext    = ACC_W'(smp_q.value);
    acc_sum  = (smp_q.first ? '0 : acc_q) + s_ext;
    clip_all = (smp_q.first ? 1'b0 : acc_clip_q) | smp_q.clip;
    unique case (smp_q.form)
      FORM_LERP: begin
        rec_base_d = acc_q;
        rec_diff_d = DIFF_W'(s_ext - acc_q);
        rec_w_d    = smp_q.weight;
      end
      FORM_AVG4: begin
        rec_base_d = acc_sum >>> AVG_SHIFT;
        rec_diff_d = '0;
        rec_w_d    = '0;
      end
      FORM_ZERO, FORM_RAW: begin
        rec_base_d = s_ext;
        rec_diff_d = '0;
        rec_w_d    = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_vld_q <= 1'b0;
    end else if (adv) begin
      rec_vld_q <= smp_vld_q && smp_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && smp_vld_q) begin
      acc_q      <= acc_sum;
      acc_clip_q <= clip_all;
      if (smp_q.last) begin
        rec_base_q <= rec_base_d;
        rec_diff_q <= rec_diff_d;
        rec_w_q    <= rec_w_d;
        rec_clip_q <= clip_all;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // blend: base + floor(diff * w / 2^16), product split in two halves
  // ---------------------------------------------------------------------------
  always_comb begin
    mul_dl    = rec_diff_q[MUL_LO_W-1:0];
    mul_dh    = rec_diff_q[DIFF_W-1:MUL_LO_W];
    mul_plo_d = mul_dl * rec_w_q;
    mul_phi_d = $signed(mul_dh) * $signed({1'b0, rec_w_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
      sum_vld_q <= 1'b0;
    end else if (adv) begin
      mul_vld_q <= rec_vld_q;
      sum_vld_q <= mul_vld_q;
    end
  end

  always_comb begin
    t_base = SUM_W'(mul_base_q);
    t_hi   = SUM_W'(mul_phi_q) <<< (MUL_LO_W - WEIGHT_FRAC);
    t_lo   = signed'(SUM_W'(mul_plo_q >> WEIGHT_FRAC));
    sum_d  = t_base + t_hi + t_lo;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mul_plo_q  <= mul_plo_d;
      mul_phi_q  <= mul_phi_d;
      mul_base_q <= rec_base_q;
      mul_clip_q <= rec_clip_q;
      sum_q      <= sum_d;
      sum_clip_q <= mul_clip_q;
    end
  end

  // ---------------------------------------------------------------------------
  // 32-bit saturation and output register
  // ---------------------------------------------------------------------------
  always_comb begin
    sum_hi  = sum_q[SUM_W-1:VAL_W-1];
    ovf_pos = !sum_q[SUM_W-1] && (|sum_hi);
    ovf_neg = sum_q[SUM_W-1] && !(&sum_hi);
    if (ovf_pos) begin
      node_d = VAL_MAX;
    end else if (ovf_neg) begin
      node_d = VAL_MIN;
    end else begin
      node_d = sum_q[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && sum_vld_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && sum_vld_q) begin
      node_value_q <= node_d;
      saturated_q  <= sum_clip_q | ovf_pos | ovf_neg;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign node_value_o = signed'(node_value_q);
  assign saturated_o  = saturated_q;

endmodule
`default_nettype wire

// ===== test/field_interpolation_gather_tb.sv =====
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// field_interpolation_gather_tb: gather datapath self-checking bench
// Loads the field memory with write beats and fires zero, raw, lerp and avg4
// evaluations at it, directed corners first and then a long random mix with
// bursty input gaps and output stalls. A scoreboard keeps its own copy of
// the field words, predicts every node value and saturation flag in order and
// compares them with what the block returns.
// -----------------------------------------------------------------------------
module field_interpolation_gather_tb;
  import fig_pkg::*;

  localparam int RANDOM_BEATS = 1030;
  localparam int HOLD_CYCLES  = 300;
  localparam longint SMP_MAX  = 64'sh7FFF_FFFF_FFFF;
  localparam longint SMP_MIN  = -64'sh8000_0000_0000;
  localparam longint NODE_MAX = 64'sd2147483647;
  localparam longint NODE_MIN = -64'sd2147483648;

  typedef struct packed {
    req_e                        req;
    logic [VAL_W-1:0]            wval;
    form_e                       form;
    logic [3:0][IDX_W-1:0]       idx;
    logic [3:0][LEN_W-1:0]       len;
    logic [WT_W-1:0]             weight;
  } beat_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             clip;
  } node_t;

  class gather_scoreboard;
    logic [VAL_W-1:0] field_words [0:FIELD_DEPTH-1];
    node_t            pending[$];
    int unsigned      errors;
    int unsigned      writes;
    int unsigned      form_count[4];
    int unsigned      results;
    int unsigned      clipped;

    function automatic longint divide_sample(logic [IDX_W-1:0] idx, logic [LEN_W-1:0] len,
                                             inout bit clip);
      logic [VAL_W-1:0] word;
      logic [VAL_W-1:0] absw;
      logic [63:0]      q;
      if (len == 0) return 0;
      word = field_words[idx];
      absw = word[VAL_W-1] ? (~word + 32'd1) : word;
      q = ({32'd0, absw} << FRAC_BITS) / {32'd0, len};
      if (!word[VAL_W-1]) begin
        if (q > 64'h7FFF_FFFF_FFFF) begin
          clip = 1'b1;
          return SMP_MAX;
        end
        return longint'(q);
      end
      if (q > 64'h8000_0000_0000) begin
        clip = 1'b1;
        return SMP_MIN;
      end
      if (q == 64'h8000_0000_0000) return SMP_MIN;
      return -longint'(q);
    endfunction

    function void note_beat(beat_t b);
      longint acc;
      longint sample_a;
      longint sample_b;
      longint wl;
      bit     clip;
      node_t  e;
      if (b.req == REQ_WRITE) begin
        field_words[b.idx[0]] = b.wval;
        writes++;
        return;
      end
      clip = 1'b0;
      form_count[b.form]++;
      case (b.form)
        FORM_RAW: begin
          acc = divide_sample(b.idx[0], b.len[0], clip);
        end
        FORM_LERP: begin
          sample_a = divide_sample(b.idx[0], b.len[0], clip);
          sample_b = divide_sample(b.idx[1], b.len[1], clip);
          wl = (b.weight > WEIGHT_ONE) ? WEIGHT_ONE : b.weight;
          acc = (sample_a * (longint'(WEIGHT_ONE) - wl) + sample_b * wl) >>> WEIGHT_FRAC;
        end
        FORM_AVG4: begin
          acc = 0;
          for (int k = 0; k < 4; k++) acc += divide_sample(b.idx[k], b.len[k], clip);
          acc = acc >>> AVG_SHIFT;
        end
        default: begin
          acc = 0;
        end
      endcase
      if (acc > NODE_MAX) begin
        acc = NODE_MAX;
        clip = 1'b1;
      end
      if (acc < NODE_MIN) begin
        acc = NODE_MIN;
        clip = 1'b1;
      end
      e.value = acc[VAL_W-1:0];
      e.clip = clip;
      pending.push_back(e);
    endfunction

    function void check_result(logic [VAL_W-1:0] v, logic s);
      node_t e;
      if (pending.size() == 0) begin
        $display("%0t unexpected beat: node_value %h saturated %b", $time, v, s);
        errors++;
        return;
      end
      e = pending.pop_front();
      results++;
      if (s === 1'b1) clipped++;
      if (v !== e.value) begin
        $display("%0t node_value expected %h actual %h", $time, e.value, v);
        errors++;
      end
      if (s !== e.clip) begin
        $display("%0t saturated expected %b actual %b", $time, e.clip, s);
        errors++;
      end
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic                    req_type_i;
  logic signed [VAL_W-1:0] write_value_i;
  logic [1:0]              form_i;
  logic [IDX_W-1:0]        index_a_i;
  logic [IDX_W-1:0]        index_b_i;
  logic [IDX_W-1:0]        index_c_i;
  logic [IDX_W-1:0]        index_d_i;
  logic [LEN_W-1:0]        length_a_i;
  logic [LEN_W-1:0]        length_b_i;
  logic [LEN_W-1:0]        length_c_i;
  logic [LEN_W-1:0]        length_d_i;
  logic [WT_W-1:0]         blend_weight_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic signed [VAL_W-1:0] node_value_o;
  logic                    saturated_o;

  gather_scoreboard sb = new();

  logic [IDX_W-1:0] filled_addrs[$];
  bit               filled [0:FIELD_DEPTH-1];
  bit               quiet_tail;
  bit               long_hold_req;

  field_interpolation_gather dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .write_value_i  (write_value_i),
    .form_i         (form_i),
    .index_a_i      (index_a_i),
    .index_b_i      (index_b_i),
    .index_c_i      (index_c_i),
    .index_d_i      (index_d_i),
    .length_a_i     (length_a_i),
    .length_b_i     (length_b_i),
    .length_c_i     (length_c_i),
    .length_d_i     (length_d_i),
    .blend_weight_i (blend_weight_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .node_value_o   (node_value_o),
    .saturated_o    (saturated_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(node_value_o, saturated_o);
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int stall_left;
    int run_left;
    stall_left = 0;
    run_left = 0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && run_left == 0 && !quiet_tail) begin
        if ($urandom_range(0, 1) == 0) stall_left = $urandom_range(1, 12);
        else run_left = $urandom_range(1, 40);
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        if (run_left > 0) run_left--;
      end
    end
  end

  initial begin
    #(5_000_000);
    $display("field_interpolation_gather: mismatch");
    $finish;
  end

  function automatic logic [VAL_W-1:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 262143)) - 131072);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] rand_length();
    case ($urandom_range(0, 9))
      0, 1: return '0;
      2, 3, 4: return $urandom;
      9: return $urandom_range(1, 16);
      default: return $urandom_range(32'h4000, 32'h10_0000);
    endcase
  endfunction

  // nonzero lengths only ever point at written words
  function automatic logic [IDX_W-1:0] pick_index(logic [LEN_W-1:0] len);
    if (len == 0) return IDX_W'($urandom);
    return filled_addrs[$urandom_range(0, filled_addrs.size() - 1)];
  endfunction

  function automatic beat_t make_write(logic [IDX_W-1:0] addr, logic [VAL_W-1:0] val);
    beat_t b;
    b.req = REQ_WRITE;
    b.wval = val;
    b.form = form_e'($urandom_range(0, 3));
    b.idx = {IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom), addr};
    b.len = {$urandom, $urandom, $urandom, $urandom};
    b.weight = WT_W'($urandom);
    if (!filled[addr]) begin
      filled[addr] = 1'b1;
      filled_addrs.push_back(addr);
    end
    return b;
  endfunction

  function automatic beat_t make_eval(form_e f,
                                      logic [IDX_W-1:0] ia, logic [IDX_W-1:0] ib,
                                      logic [IDX_W-1:0] ic, logic [IDX_W-1:0] id,
                                      logic [LEN_W-1:0] la, logic [LEN_W-1:0] lb,
                                      logic [LEN_W-1:0] lc, logic [LEN_W-1:0] ld,
                                      logic [WT_W-1:0] w);
    beat_t b;
    b.req = REQ_EVAL;
    b.wval = $urandom;
    b.form = f;
    b.idx = {id, ic, ib, ia};
    b.len = {ld, lc, lb, la};
    b.weight = w;
    return b;
  endfunction

  function automatic beat_t rand_eval();
    logic [3:0][LEN_W-1:0] l;
    logic [WT_W-1:0]       w;
    for (int k = 0; k < 4; k++) l[k] = rand_length();
    case ($urandom_range(0, 5))
      0: w = '0;
      1: w = WEIGHT_ONE;
      2: w = WT_W'($urandom_range(0, 131071));
      default: w = WT_W'($urandom_range(0, 65536));
    endcase
    return make_eval(form_e'($urandom_range(0, 3)), pick_index(l[0]), pick_index(l[1]),
                     pick_index(l[2]), pick_index(l[3]), l[0], l[1], l[2], l[3], w);
  endfunction

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic send_beat(input beat_t b);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    req_type_i     <= b.req;
    write_value_i  <= b.wval;
    form_i         <= b.form;
    index_a_i      <= b.idx[0];
    index_b_i      <= b.idx[1];
    index_c_i      <= b.idx[2];
    index_d_i      <= b.idx[3];
    length_a_i     <= b.len[0];
    length_b_i     <= b.len[1];
    length_c_i     <= b.len[2];
    length_d_i     <= b.len[3];
    blend_weight_i <= b.weight;
    in_valid_i     <= 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_beat(b);
    @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    req_type_i = REQ_WRITE;
    write_value_i = '0;
    form_i = FORM_ZERO;
    index_a_i = '0;
    index_b_i = '0;
    index_c_i = '0;
    index_d_i = '0;
    length_a_i = '0;
    length_b_i = '0;
    length_c_i = '0;
    length_d_i = '0;
    blend_weight_i = '0;
    out_stall_i = 1'b0;
    quiet_tail = 1'b0;
    long_hold_req = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(negedge clk_i);

    // directed corners
    send_beat(make_write(16'h0000, 32'h7FFF_FFFF));
    send_beat(make_write(16'hFFFF, 32'h8000_0000));
    send_beat(make_write(16'h5555, 32'hFFFF_FFFF));
    send_beat(make_write(16'hAAAA, 32'h0001_0000));
    send_beat(make_write(16'h1234, 32'hFFFE_8000));
    send_beat(make_eval(FORM_ZERO, 16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA,
                        32'h1, 32'hFFFF_FFFF, 32'h1_0000, 32'h3, 17'd0));
    send_beat(make_eval(FORM_RAW, 16'h0000, 16'h0, 16'h0, 16'h0,
                        32'h1, 32'h0, 32'h0, 32'h0, 17'd0));
    send_beat(make_eval(FORM_RAW, 16'hFFFF, 16'h0, 16'h0, 16'h0,
                        32'h1, 32'h0, 32'h0, 32'h0, 17'd0));
    send_beat(make_eval(FORM_RAW, 16'hAAAA, 16'h0, 16'h0, 16'h0,
                        32'h1_0000, 32'h0, 32'h0, 32'h0, 17'd0));
    send_beat(make_eval(FORM_RAW, 16'hBEEF, 16'h0, 16'h0, 16'h0,
                        32'h0, 32'h0, 32'h0, 32'h0, 17'd0));
    send_beat(make_eval(FORM_RAW, 16'h1234, 16'h0, 16'h0, 16'h0,
                        32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 17'd0));
    send_beat(make_eval(FORM_RAW, 16'h5555, 16'h0, 16'h0, 16'h0,
                        32'h3_0000, 32'h0, 32'h0, 32'h0, 17'd0));
    send_beat(make_eval(FORM_LERP, 16'hAAAA, 16'h1234, 16'h0, 16'h0,
                        32'h1_0000, 32'h1_0000, 32'h0, 32'h0, 17'd0));
    send_beat(make_eval(FORM_LERP, 16'hAAAA, 16'h1234, 16'h0, 16'h0,
                        32'h1_0000, 32'h1_0000, 32'h0, 32'h0, WEIGHT_ONE));
    send_beat(make_eval(FORM_LERP, 16'hAAAA, 16'h1234, 16'h0, 16'h0,
                        32'h1_0000, 32'h1_0000, 32'h0, 32'h0, 17'h1_FFFF));
    send_beat(make_eval(FORM_LERP, 16'h5555, 16'hAAAA, 16'h0, 16'h0,
                        32'h3_0000, 32'h3_0000, 32'h0, 32'h0, 17'd32768));
    send_beat(make_eval(FORM_LERP, 16'h0000, 16'hFFFF, 16'h0, 16'h0,
                        32'h1, 32'h1, 32'h0, 32'h0, 17'd32768));
    send_beat(make_eval(FORM_AVG4, 16'h5555, 16'h1234, 16'hAAAA, 16'h5555,
                        32'h1_0000, 32'h1_0000, 32'h1_0000, 32'h1_0000, 17'd0));
    send_beat(make_eval(FORM_AVG4, 16'h1234, 16'h7777, 16'hAAAA, 16'h8888,
                        32'h2_0000, 32'h0, 32'h7_0000, 32'h0, 17'd0));
    send_beat(make_eval(FORM_AVG4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                        32'h1, 32'h1, 32'h1, 32'h1, 17'd0));
    send_beat(make_eval(FORM_AVG4, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                        32'h1, 32'h1, 32'h1, 32'h1, 17'd0));
    send_beat(make_write(16'hAAAA, 32'h0000_0001));
    send_beat(make_eval(FORM_RAW, 16'hAAAA, 16'h0, 16'h0, 16'h0,
                        32'h1_0000, 32'h0, 32'h0, 32'h0, 17'd0));
    send_beat(make_eval(FORM_ZERO, 16'h0, 16'h0, 16'h0, 16'h0,
                        32'h0, 32'h0, 32'h0, 32'h0, 17'd0));

    // random mix, one long receiver hold-off, calm tail
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n == 350) long_hold_req = 1'b1;
      if (n == RANDOM_BEATS - 120) quiet_tail = 1'b1;
      if ($urandom_range(0, 9) < 3)
        send_beat(make_write(($urandom_range(0, 1) == 0) ? pick_index(32'h1) :
                             IDX_W'($urandom), rand_word()));
      else
        send_beat(rand_eval());
    end
    in_valid_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);

    $display("covered %0d field writes, evaluations zero %0d raw %0d lerp %0d avg4 %0d",
             sb.writes, sb.form_count[FORM_ZERO], sb.form_count[FORM_RAW],
             sb.form_count[FORM_LERP], sb.form_count[FORM_AVG4]);
    $display("%0d results checked, %0d clipped, %0d errors", sb.results, sb.clipped, sb.errors);
    if (sb.errors == 0) begin
      $display("field_interpolation_gather: match");
    end else begin
      $display("field_interpolation_gather: mismatch");
    end
    $finish;
  end

endmodule

// ===== field_interpolation_gather.f =====
rtl/fig_pkg.sv
rtl/fig_ram.sv
rtl/field_interpolation_gather.sv
test/field_interpolation_gather_tb.sv
